// File: rtl/core/bitmap_page_frame_allocator_top_macros.svh
// Assertion macros used by the page frame allocator datapath.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BPFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpfa: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpfa: next-cycle check failed");

`endif

// File: rtl/core/bpfa_pkg.sv
// Package: constants, codes, command/status structs and map helpers for the allocator.
`default_nettype none
package bpfa_pkg;

   localparam int PAGE_COUNT     = 4096;
   localparam int RESERVED_PAGES = 512;

   localparam int PAGE_SHIFT   = 12;
   localparam int MAP_WORDS    = (PAGE_COUNT + 31) / 32;
   localparam int WORD_AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PG_W         = $clog2(PAGE_COUNT);
   localparam int RES_CLAMP    = (RESERVED_PAGES > PAGE_COUNT) ? PAGE_COUNT : RESERVED_PAGES;
   localparam int ADDR_OUT_W   = 24;

   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

   // Request action codes.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_ALLOCATED    = 2'd0;
   localparam logic [1:0] ST_NONE_FREE    = 2'd1;
   localparam logic [1:0] ST_FREED        = 2'd2;
   localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

   typedef struct packed {
      logic capture;      // latch request page index and range flag
      logic scan_start;   // read map word 0, pointer to 1
      logic scan_next;    // read word at pointer, pointer advances
      logic free_read;    // read the word holding the freed page
      logic alloc_write;  // set lowest free bit of checked word, record address
      logic free_write;   // clear the freed page bit
      logic set_none;     // record map-full result
      logic set_oor;      // record out-of-range result
      logic out_load;     // move recorded result into the output register
   } bpfa_cmd_type;

   typedef struct packed {
      logic word_free;    // checked word has a free page
      logic last_word;    // checked word is the last map word
      logic out_free;     // output register can take a beat
      logic req_in_range; // page of the presented request is inside the map
   } bpfa_stat_type;

   // Map word value after reset: reserved pages read as used.
   function automatic logic [31:0] reset_word(input logic [WORD_AW-1:0] w);
      logic [31:0] r;
      int          base;
      base = int'(w) * 32;
      for (int i = 0; i < 32; i++) begin
         r[i] = (base + i) < RES_CLAMP;
      end
      return r;
   endfunction

   // Bits of a map word that stand for real pages.
   function automatic logic [31:0] page_mask(input logic [WORD_AW-1:0] w);
      logic [31:0] r;
      int          base;
      base = int'(w) * 32;
      for (int i = 0; i < 32; i++) begin
         r[i] = (base + i) < PAGE_COUNT;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/bpfa_ctrl.sv
// Controller state machine: sequences scan, read-modify-write and result load.
`default_nettype none
module bpfa_ctrl
   import bpfa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_action,
   output logic               req_ready,
   input  wire bpfa_stat_type stat,
   output bpfa_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_SCAN_START = 3'd1;
   localparam logic [2:0] S_SCAN       = 3'd2;
   localparam logic [2:0] S_FREE_RD    = 3'd3;
   localparam logic [2:0] S_FREE_WR    = 3'd4;
   localparam logic [2:0] S_LOAD       = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_action == ACT_ALLOC) begin
                  state_in = S_SCAN_START;
               end else if (stat.req_in_range) begin
                  state_in = S_FREE_RD;
               end else begin
                  cmd.set_oor = 1'b1;
                  state_in    = S_LOAD;
               end
            end
         end
         S_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (stat.word_free) begin
               cmd.alloc_write = 1'b1;
               state_in        = S_LOAD;
            end else if (stat.last_word) begin
               cmd.set_none = 1'b1;
               state_in     = S_LOAD;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_FREE_RD: begin
            cmd.free_read = 1'b1;
            state_in      = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.free_write = 1'b1;
            state_in       = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/bpfa_datapath.sv
// Datapath: used-map memory with valid bits, scan pointer, bit search and result registers.
`default_nettype none
`include "bitmap_page_frame_allocator_top_macros.svh"
module bpfa_datapath
   import bpfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bpfa_cmd_type          cmd,
   input  wire logic [31:0]           req_address,
   input  wire logic                  rsp_ready,
   output bpfa_stat_type              stat,
   output logic                       rsp_valid,
   output logic [ADDR_OUT_W-1:0]      rsp_page_address,
   output logic [1:0]                 rsp_status
);

   // map storage
   logic [31:0]          mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] word_valid_ff;
   logic [31:0]          rdata_ff;
   logic                 rvalid_ff;
   logic [WORD_AW-1:0]   raddr_ff;

   logic [WORD_AW-1:0]   ptr_ff;
   logic [WORD_AW-1:0]   ptr_in;
   logic [PG_W-1:0]      pg_ff;
   logic                 in_range_ff;

   logic [ADDR_OUT_W-1:0] res_addr_ff;
   logic [1:0]            res_status_ff;
   logic                  rsp_valid_ff;
   logic [ADDR_OUT_W-1:0] rsp_addr_ff;
   logic [1:0]            rsp_status_ff;

   logic                 rd_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic [WORD_AW-1:0]   pg_word;
   logic [31:0]          word_cur;
   logic [31:0]          scan_word;
   logic [4:0]           zero_idx;
   logic                 wr_en;
   logic [31:0]          wr_data;
   logic [PG_W-1:0]      found_pg;

   assign pg_word  = WORD_AW'(pg_ff >> 5);
   assign rd_en    = cmd.scan_start | cmd.scan_next | cmd.free_read;

   always_comb begin
      rd_addr = pg_word;
      if (cmd.scan_start) begin
         rd_addr = '0;
      end else if (cmd.scan_next) begin
         rd_addr = ptr_ff;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.scan_start) begin
         ptr_in = WORD_AW'(1);
      end else if (cmd.scan_next) begin
         ptr_in = ptr_ff + WORD_AW'(1);
      end
   end

   // unwritten words read as their reset pattern; pages past the map count as used
   assign word_cur  = rvalid_ff ? rdata_ff : reset_word(raddr_ff);
   assign scan_word = word_cur | ~page_mask(raddr_ff);

   always_comb begin
      zero_idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (!scan_word[i]) begin
            zero_idx = 5'(i);
         end
      end
   end

   assign found_pg = (PG_W'(raddr_ff) << 5) | PG_W'(zero_idx);
   assign wr_en    = cmd.alloc_write | cmd.free_write;

   always_comb begin
      if (cmd.free_write) begin
         wr_data = word_cur & ~(32'd1 << pg_ff[4:0]);
      end else begin
         wr_data = word_cur | (32'd1 << zero_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[raddr_ff] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rvalid_ff     <= 1'b0;
         raddr_ff      <= '0;
         ptr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         if (wr_en) begin
            word_valid_ff[raddr_ff] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= word_valid_ff[rd_addr];
            raddr_ff  <= rd_addr;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pg_ff       <= req_address[PAGE_SHIFT +: PG_W];
         in_range_ff <= stat.req_in_range;
      end
      if (cmd.alloc_write) begin
         res_addr_ff   <= ADDR_OUT_W'(found_pg) << PAGE_SHIFT;
         res_status_ff <= ST_ALLOCATED;
      end else if (cmd.set_none) begin
         res_addr_ff   <= '0;
         res_status_ff <= ST_NONE_FREE;
      end else if (cmd.free_write) begin
         res_addr_ff   <= '0;
         res_status_ff <= ST_FREED;
      end else if (cmd.set_oor) begin
         res_addr_ff   <= '0;
         res_status_ff <= ST_OUT_OF_RANGE;
      end
      if (cmd.out_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign stat.word_free    = scan_word != '1;
   assign stat.last_word    = raddr_ff == LAST_WORD;
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;
   assign stat.req_in_range = req_address[31:PAGE_SHIFT] < (32 - PAGE_SHIFT)'(PAGE_COUNT);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   `BPFA_ASSERT_NOW(a_alloc_has_free, clock, reset, cmd.alloc_write, stat.word_free)
   `BPFA_ASSERT_NOW(a_one_writer, clock, reset, 1'b1, $onehot0({cmd.alloc_write, cmd.free_write}))
   `BPFA_ASSERT_NOW(a_free_in_range, clock, reset, cmd.free_read, in_range_ff)
   `BPFA_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid_ff)

endmodule
`default_nettype wire

// File: rtl/core/bitmap_page_frame_allocator_top.sv
// Top level of the bitmap first-fit page frame allocator.
//
//   channel | ports                                   | dir | beat
//   --------+-----------------------------------------+-----+--------------------------------
//   req     | req_valid req_ready req_action          | in  | allocate, or free one page
//           | req_address                             |     |
//   rsp     | rsp_valid rsp_ready rsp_page_address    | out | one beat per request
//           | rsp_status                              |     |
//
// An in-range free goes from accept to result through accept, map read, map
// write and load; an out-of-range free through accept and load. An allocate
// goes through accept and scan start, then reads map words from word 0 up to
// the first with a free page (to the last for a full map), then load; the
// scan reads one map word per cycle through the single map read port.
// One request is in flight at a time; req_ready is high only when idle.
// Reset (synchronous, active high) clears the word valid bits, so the map
// reads with the reserved pages used at once; there is no clearing pass.
// A stalled rsp holds its beat; the finished result waits in the load step
// until the output register frees, and the map is already updated by then.
`default_nettype none
module bitmap_page_frame_allocator_top
   import bpfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_action,
   input  wire logic [31:0]           req_address,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [ADDR_OUT_W-1:0]      rsp_page_address,
   output logic [1:0]                 rsp_status
);

   bpfa_cmd_type  cmd;
   bpfa_stat_type stat;

   // sequencing
   bpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // map, search and result registers
   bpfa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_address      (req_address),
      .rsp_ready        (rsp_ready),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_page_address (rsp_page_address),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire
